[rtl/anbx_pkg.sv]
// Package for the Annex B NAL unit indexer: word types, codes and limits.
// Used by anbx_scan and annexb_nal_indexer; depends on nothing else.
`timescale 1ns / 1ps

package anbx_pkg;

  // Packet limits and field widths.
  localparam int unsigned POS_W               = 23;
  localparam int unsigned OFFSET_W            = 22;
  localparam int unsigned FILL_W              = 23;
  localparam logic [POS_W-1:0]  MAX_PACKET_BYTES    = 23'd4194304;
  localparam logic [POS_W-1:0]  MAX_PARAM_SET_BYTES = 23'd65535;
  localparam logic [FILL_W:0]   FILL_MAX            = 24'd8388607;
  localparam logic [FILL_W:0]   LEN_PREFIX_BYTES    = 24'd4;
  localparam logic [POS_W-1:0]  SPS_MIN_BYTES       = 23'd4;
  localparam int unsigned       HEAD_BYTES          = 4;

  // NAL unit types that get special handling.
  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

  // Descriptor kinds.
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_SPS     = 2'd1;
  localparam logic [1:0] KIND_PPS     = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_NO_START  = 2'd1;
  localparam logic [1:0] ERR_PS_LONG   = 2'd2;
  localparam logic [1:0] ERR_SPS_SHORT = 2'd3;

  // Input word: one packet byte with its framing flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
    logic       frame_start;
  } in_word_t;

  // Output word: one NAL unit descriptor.
  typedef struct packed {
    logic [21:0] nal_offset;
    logic [22:0] nal_length;
    logic [1:0]  nal_kind_code;
    logic [4:0]  unit_type;
    logic [22:0] payload_position;
    logic [7:0]  profile_byte;
    logic [7:0]  compat_byte;
    logic [7:0]  level_byte;
    logic [1:0]  error_code;
    logic        closes_packet;
  } out_word_t;

endpackage

[rtl/anbx_scan.sv]
// Start-code scanner state and descriptor builder for the NAL unit indexer.
// Depends on anbx_pkg for word types, codes and limits.
`timescale 1ns / 1ps

module anbx_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  anbx_pkg::in_word_t word,
  output logic               emit,
  output anbx_pkg::out_word_t result
);

  logic [1:0]                       zero_run_r, zero_run_nxt;
  logic [anbx_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                             open_r, open_nxt;
  logic [anbx_pkg::POS_W-1:0]       begin_r, begin_nxt;
  logic [anbx_pkg::HEAD_BYTES-1:0][7:0] head_r, head_nxt;
  logic [2:0]                       head_cnt_r, head_cnt_nxt;
  logic [anbx_pkg::FILL_W-1:0]      fill_r, fill_nxt;

  logic                             active;
  logic                             start_code;
  logic [anbx_pkg::POS_W-1:0]       pos_inc;
  logic [anbx_pkg::POS_W-1:0]       code_start;
  logic                             unit_emit;
  logic                             last_unit;
  logic                             use_unit;
  logic                             open_after;
  logic [anbx_pkg::POS_W-1:0]       begin_after;
  logic [anbx_pkg::POS_W-1:0]       unit_len;
  logic [anbx_pkg::HEAD_BYTES-1:0][7:0] head_w;
  logic [2:0]                       head_cnt_w;
  logic [anbx_pkg::FILL_W-1:0]      fill_base;
  logic [anbx_pkg::FILL_W:0]        fill_sum;
  logic [4:0]                       nal_type;

  // Byte bookkeeping, start-code detection and head capture.
  always_comb begin
    active     = (pos_r < anbx_pkg::MAX_PACKET_BYTES);
    pos_inc    = pos_r + 23'd1;
    fill_base  = word.frame_start ? '0 : fill_r;
    head_w     = head_r;
    head_cnt_w = head_cnt_r;
    if (active && open_r && (head_cnt_r < 3'(anbx_pkg::HEAD_BYTES))) begin
      head_w[head_cnt_r[1:0]] = word.data_byte;
      head_cnt_w              = head_cnt_r + 3'd1;
    end
    start_code  = active && (word.data_byte == 8'd1) && (zero_run_r >= 2'd2);
    code_start  = pos_r - {21'd0, zero_run_r};
    unit_emit   = start_code && open_r && (code_start > begin_r);
    open_after  = open_r || start_code;
    begin_after = start_code ? pos_inc : begin_r;
    pos_nxt     = active ? pos_inc : pos_r;
    last_unit   = word.packet_end && !unit_emit && open_after && (pos_nxt > begin_after);
    use_unit    = unit_emit || last_unit;
    unit_len    = unit_emit ? (code_start - begin_r) : (pos_nxt - begin_r);
    emit        = unit_emit || word.packet_end;
    nal_type    = head_w[0][4:0];
    fill_sum    = {1'b0, fill_base} + anbx_pkg::LEN_PREFIX_BYTES + {1'b0, unit_len};
  end

  // Descriptor for the finished unit, or the empty packet-close word.
  always_comb begin
    result               = '0;
    result.closes_packet = word.packet_end;
    fill_nxt             = fill_base;
    if (use_unit) begin
      result.nal_offset = begin_r[anbx_pkg::OFFSET_W-1:0];
      result.nal_length = unit_len;
      result.unit_type  = nal_type;
      if (nal_type == anbx_pkg::NAL_TYPE_SPS) begin
        result.nal_kind_code = anbx_pkg::KIND_SPS;
        if (unit_len < anbx_pkg::SPS_MIN_BYTES) begin
          result.error_code = anbx_pkg::ERR_SPS_SHORT;
        end else if (unit_len > anbx_pkg::MAX_PARAM_SET_BYTES) begin
          result.error_code = anbx_pkg::ERR_PS_LONG;
        end else begin
          result.profile_byte = head_w[1];
          result.compat_byte  = head_w[2];
          result.level_byte   = head_w[3];
        end
      end else if (nal_type == anbx_pkg::NAL_TYPE_PPS) begin
        result.nal_kind_code = anbx_pkg::KIND_PPS;
        if (unit_len > anbx_pkg::MAX_PARAM_SET_BYTES) begin
          result.error_code = anbx_pkg::ERR_PS_LONG;
        end
      end else begin
        result.nal_kind_code    = anbx_pkg::KIND_PAYLOAD;
        result.payload_position = fill_base;
        fill_nxt = (fill_sum > anbx_pkg::FILL_MAX) ?
                   anbx_pkg::FILL_MAX[anbx_pkg::FILL_W-1:0] :
                   fill_sum[anbx_pkg::FILL_W-1:0];
      end
    end else if (!open_after) begin
      result.error_code = anbx_pkg::ERR_NO_START;
    end
  end

  // Next scanner state; the last byte of a packet clears all but the fill.
  always_comb begin
    zero_run_nxt = zero_run_r;
    open_nxt     = open_after;
    begin_nxt    = begin_after;
    head_nxt     = head_w;
    head_cnt_nxt = head_cnt_w;
    if (active) begin
      if (word.data_byte == 8'd0) begin
        if (zero_run_r != 2'd3) begin
          zero_run_nxt = zero_run_r + 2'd1;
        end
      end else begin
        zero_run_nxt = 2'd0;
      end
    end
    if (start_code) begin
      head_nxt     = '0;
      head_cnt_nxt = 3'd0;
    end
    if (word.packet_end) begin
      zero_run_nxt = 2'd0;
      open_nxt     = 1'b0;
      begin_nxt    = '0;
      head_nxt     = '0;
      head_cnt_nxt = 3'd0;
    end
  end

  // Scanner state registers, updated once per word taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= 2'd0;
      pos_r      <= '0;
      open_r     <= 1'b0;
      begin_r    <= '0;
      head_r     <= '0;
      head_cnt_r <= 3'd0;
      fill_r     <= '0;
    end else if (step) begin
      zero_run_r <= zero_run_nxt;
      pos_r      <= word.packet_end ? '0 : pos_nxt;
      open_r     <= open_nxt;
      begin_r    <= begin_nxt;
      head_r     <= head_nxt;
      head_cnt_r <= head_cnt_nxt;
      fill_r     <= fill_nxt;
    end
  end

endmodule

[rtl/annexb_nal_indexer.sv]
// Annex B NAL unit indexer: top level with input register and output register.
// A byte taken into the input register passes through the scanner into the output
// register when it moves on, and its descriptor then shows on out_word.
// Throughput: one byte per cycle; a byte waits only when it makes a descriptor while
// the output register holds one that out_stall keeps in place.
// Reset: synchronous active-low rst_n clears the valid flags of both stages and the scanner state.
`timescale 1ns / 1ps

module annexb_nal_indexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  anbx_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output anbx_pkg::out_word_t out_word
);

  logic                s1_valid_r, s1_valid_nxt;
  anbx_pkg::in_word_t  s1_word_r;
  logic                out_valid_r, out_valid_nxt;
  anbx_pkg::out_word_t out_word_r;

  logic                out_free;
  logic                s1_go;
  logic                in_take;
  logic                emit;
  anbx_pkg::out_word_t result;

  anbx_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .word   (s1_word_r),
    .emit   (emit),
    .result (result)
  );

  // Handshake: the held word moves on when it makes no descriptor or its result has a free slot.
  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_go         = s1_valid_r && (out_free || !emit);
    in_stall      = s1_valid_r && !s1_go;
    in_take       = in_valid && !in_stall;
    s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_go && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (s1_go && emit) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  // The last byte of a packet always produces a descriptor.
  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_word_r.packet_end) |=> (out_valid && out_word.closes_packet))
    else $error("packet end produced no descriptor");

  // The input side only stalls when the held word cannot move on.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && emit && out_valid_r && out_stall))
    else $error("input stalled without cause");

  // An empty descriptor only appears when a packet closes.
  a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.nal_kind_code == anbx_pkg::KIND_NONE)) |->
    (out_word.closes_packet && (out_word.nal_length == 23'd0)))
    else $error("empty descriptor outside packet close");

  // A short sequence set error belongs to a sequence set under four bytes.
  a_sps_short: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.error_code == anbx_pkg::ERR_SPS_SHORT)) |->
    ((out_word.nal_kind_code == anbx_pkg::KIND_SPS) &&
     (out_word.nal_length < anbx_pkg::SPS_MIN_BYTES)))
    else $error("short sequence set error on wrong descriptor");
`endif

endmodule
